/* rtl/core/first_fit_heap_allocator_assert.svh */
// Assertion macros for the first-fit heap allocator.
// Included by the modules that check their own logic; no other dependency.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define FFHA_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define FFHA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define FFHA_ASSERT(label, clk, rstn, prop)
`define FFHA_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/core/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;
  localparam int HeapBytesMaxDef = 65536;
  localparam int Granule         = 16;
  localparam int SizeW           = 17;
  localparam int AddrW           = 32;

  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam int RegHeapBase  = 0;
  localparam int RegHeapBytes = 1;
endpackage

/* rtl/core/ffha_tag_ram.sv */
// Tag memory: one write port, one registered read port.
// Depends on nothing but its parameters.
module ffha_tag_ram #(
  parameter int Depth = 4096,
  parameter int Width = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: sequencer, shared adder, tags.
// Depends on ffha_pkg, ffha_tag_ram and the assertion header.
//
// One operation at a time; in_ready is high only while the block is idle.
// A valid free passes through S_FRD, S_FWT, S_FNX, S_FPV, S_FPW, S_FMG and
// S_FWR2 before out_valid rises. An allocate walks the heap one block at a time
// through the single read port of the header tag memory; each visited block,
// the terminator included, takes S_ARD, S_AWT and S_ACHK. A split adds S_AS1
// and S_AS2. A format writes the terminator and the first free block, then runs
// the prologue allocate.
// After the result beat is taken the block is ready again in the next cycle.
// The tag memories have no reset; run a format first.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HeapBytesMax = HeapBytesMaxDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [15:0]                in_request_size,
  input  logic [31:0]                in_block_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic [31:0]                out_result_address,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  localparam int Depth = HeapBytesMax / Granule;
  localparam int GW    = $clog2(Depth);
  localparam int CW    = GW + 3;   // granule counter, holds values past the store
  localparam int HBW   = $clog2(HeapBytesMax + 1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_FMT1  = 16'h0002,
    S_FMT2  = 16'h0004,
    S_ARD   = 16'h0008,
    S_AWT   = 16'h0010,
    S_ACHK  = 16'h0020,
    S_AS1   = 16'h0040,
    S_AS2   = 16'h0080,
    S_FRD   = 16'h0100,
    S_FWT   = 16'h0200,
    S_FNX   = 16'h0400,
    S_FPV   = 16'h0800,
    S_FPW   = 16'h1000,
    S_FMG   = 16'h2000,
    S_FWR2  = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] heap_base_r;
  logic [16:0] heap_bytes_r;
  logic        fmt_r, fmt_nxt;
  logic        status_r, status_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [CW-1:0] p_r, p_nxt, q_r, q_nxt, pp_r, pp_nxt;
  logic [SizeW-1:0] need_r, need_nxt, s_r, s_nxt, ps_r, ps_nxt, ns_r, ns_nxt;
  logic        pf_r, pf_nxt, nf_r, nf_nxt;
  logic        pv_r, pv_nxt, nv_r, nv_nxt;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0:    prdata = heap_base_r;
      default: prdata = {15'd0, heap_bytes_r};
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      heap_bytes_r <= 17'd65536;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == 3'(4 * RegHeapBase)) heap_base_r <= pwdata;
      else if (paddr == 3'(4 * RegHeapBytes)) heap_bytes_r <= pwdata[16:0];
    end
  end

  // Effective heap size in bytes and in granules.
  logic [HBW-1:0] eff_bytes;
  logic [CW-1:0]  term_g;
  always_comb begin
    logic [16:0] h;
    h = {heap_bytes_r[16:4], 4'd0};
    if (h < 17'd64) eff_bytes = HBW'(64);
    else if (HBW'(h) > HBW'(HeapBytesMax) || (HBW < 17 && h[16]))
      eff_bytes = HBW'(HeapBytesMax);
    else eff_bytes = HBW'(h);
    term_g = CW'(eff_bytes >> 4);
  end

  // Tag memories.
  logic            hwe, fwe;
  logic [CW-1:0]   hwa, fwa, hra, fra;
  logic [17:0]     hwd, hrd;
  logic [16:0]     fwd, frd;
  ffha_tag_ram #(.Depth(Depth), .Width(18)) u_hdr (
    .clk(clk), .we(hwe && hwa < CW'(Depth)), .waddr(hwa[GW-1:0]), .wdata(hwd),
    .raddr(hra[GW-1:0]), .rdata(hrd));
  ffha_tag_ram #(.Depth(Depth), .Width(17)) u_ftr (
    .clk(clk), .we(fwe && fwa < CW'(Depth)), .waddr(fwa[GW-1:0]), .wdata(fwd),
    .raddr(fra[GW-1:0]), .rdata(frd));

  // Out-of-range reads are tracked by a flag registered alongside the read.
  logic hoob_r, foob_r;
  logic [17:0] hdr_v;
  logic [16:0] ftr_v;
  assign hdr_v = hoob_r ? 18'h20000 : hrd;
  assign ftr_v = foob_r ? 17'd0 : frd;
  always_ff @(posedge clk) begin
    hoob_r <= !(hra < CW'(Depth));
    foob_r <= !(fra < CW'(Depth));
  end

  // Shared adder for sizes and granule indexes.
  logic [CW-1:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  logic [31:0] d_off;
  logic [31:0] need_calc;
  assign d_off     = in_block_address - heap_base_r;
  assign need_calc = ({16'd0, in_request_size} + 32'd31) & ~32'd15;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_status         = status_r;
  assign out_result_address = addr_r;

  // Sequencer.
  always_comb begin
    logic [SizeW-1:0] extra, sz;
    logic [CW-1:0]    m;
    state_nxt = state_r;
    fmt_nxt = fmt_r; status_nxt = status_r; addr_nxt = addr_r;
    p_nxt = p_r; q_nxt = q_r; pp_nxt = pp_r; need_nxt = need_r; s_nxt = s_r;
    ps_nxt = ps_r; ns_nxt = ns_r; pf_nxt = pf_r; nf_nxt = nf_r;
    pv_nxt = pv_r; nv_nxt = nv_r;
    hwe = 1'b0; hwa = '0; hwd = '0; fwe = 1'b0; fwa = '0; fwd = '0;
    hra = p_r - CW'(1); fra = p_r - CW'(1);
    add_a = p_r; add_b = CW'(s_r >> 4);
    extra = s_r - need_r;
    sz = '0; m = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = 1'b0; addr_nxt = '0; fmt_nxt = 1'b0;
          p_nxt = CW'(1);
          unique case (opcode_t'(in_opcode))
            OP_FORMAT: begin
              fmt_nxt = 1'b1; need_nxt = SizeW'(16);
              hwe = 1'b1; hwa = term_g - CW'(1); hwd = 18'h20000;
              state_nxt = S_FMT1;
            end
            OP_ALLOC: begin
              need_nxt = need_calc[SizeW-1:0];
              state_nxt = S_ARD;
            end
            OP_FREE: begin
              p_nxt = CW'(d_off >> 4);
              if (d_off[3:0] != 4'd0 || d_off[31:4] == 28'd0 ||
                  d_off[31:4] >= 28'(term_g)) state_nxt = S_OUT;
              else state_nxt = S_FRD;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_FMT1: begin
        hwe = 1'b1; hwa = '0; hwd = {1'b0, SizeW'(eff_bytes - HBW'(16))};
        fwe = 1'b1; fwa = term_g - CW'(1); fwd = SizeW'(eff_bytes - HBW'(16));
        state_nxt = S_ARD;
      end
      // Walk: issue read of header p-1.
      S_ARD: begin
        if (p_r - CW'(1) >= CW'(Depth)) begin
          status_nxt = !fmt_r; state_nxt = S_OUT;
        end else state_nxt = S_AWT;
      end
      S_AWT: begin
        s_nxt = hdr_v[16:0];
        state_nxt = S_ACHK;
      end
      S_ACHK: begin
        if (s_r[16:4] == '0) begin
          status_nxt = !fmt_r; state_nxt = S_OUT;
        end else if (!hdr_v[17] && s_r >= need_r) begin
          if (extra > SizeW'(32)) begin
            add_b = CW'(need_r >> 4);
            q_nxt = add_y;
            state_nxt = S_AS1;
          end else begin
            hwe = 1'b1; hwa = p_r - CW'(1); hwd = {1'b1, s_r};
            // The prologue allocate of a format reports no address.
            addr_nxt = fmt_r ? '0 : heap_base_r + 32'({p_r, 4'd0});
            state_nxt = S_OUT;
          end
        end else begin
          p_nxt = add_y;
          state_nxt = S_ARD;
        end
      end
      S_AS1: begin
        fwe = 1'b1; fwa = q_r - CW'(1); fwd = need_r;
        hwe = 1'b1; hwa = q_r - CW'(1); hwd = {1'b0, extra};
        state_nxt = S_AS2;
      end
      S_AS2: begin
        add_a = q_r; add_b = CW'(extra >> 4);
        fwe = 1'b1; fwa = add_y - CW'(1); fwd = extra;
        hwe = 1'b1; hwa = p_r - CW'(1); hwd = {1'b1, need_r};
        addr_nxt = fmt_r ? '0 : heap_base_r + 32'({p_r, 4'd0});
        state_nxt = S_OUT;
      end
      // Free: read own header and left footer.
      S_FRD: state_nxt = S_FWT;
      S_FWT: begin
        s_nxt = hdr_v[16:0];
        hwe = 1'b1; hwa = p_r - CW'(1); hwd = {1'b0, hdr_v[16:0]};
        m = CW'(ftr_v >> 4);
        pv_nxt = (p_r > CW'(1)) && (m >= CW'(1)) && (m < p_r);
        pp_nxt = p_r - m;
        add_b = CW'(hdr_v[16:4]);
        q_nxt = add_y;
        nv_nxt = hdr_v[16:4] != '0;
        state_nxt = S_FNX;
      end
      S_FNX: begin
        hra = q_r - CW'(1);
        state_nxt = S_FPV;
      end
      S_FPV: begin
        nf_nxt = nv_r && !hdr_v[17];
        ns_nxt = hdr_v[16:0];
        hra = pp_r - CW'(1);
        state_nxt = S_FPW;
      end
      // Keep the left neighbor's header address on the read port in S_FPW as well.
      S_FPW: begin
        hra = pp_r - CW'(1);
        state_nxt = S_FMG;
      end
      S_FMG: begin
        pf_nxt = pv_r && !hdr_v[17];
        ps_nxt = hdr_v[16:0];
        state_nxt = S_FWR2;
      end
      S_FWR2: begin
        if (!pf_r && nf_r) begin
          sz = s_r + ns_r;
          hwe = 1'b1; hwa = p_r - CW'(1); hwd = {1'b0, sz};
          add_b = CW'(sz >> 4);
          fwe = 1'b1; fwa = add_y - CW'(1); fwd = sz;
        end else if (pf_r && !nf_r) begin
          sz = s_r + ps_r;
          fwe = 1'b1; fwa = q_r - CW'(1); fwd = sz;
          hwe = 1'b1; hwa = pp_r - CW'(1); hwd = {1'b0, sz};
        end else if (pf_r && nf_r) begin
          sz = s_r + ps_r + ns_r;
          hwe = 1'b1; hwa = pp_r - CW'(1); hwd = {1'b0, sz};
          add_a = q_r; add_b = CW'(ns_r >> 4);
          fwe = 1'b1; fwa = add_y - CW'(1); fwd = sz;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= 1'b0;
      addr_r   <= '0;
      fmt_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      addr_r   <= addr_nxt;
      fmt_r    <= fmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; q_r <= q_nxt; pp_r <= pp_nxt; need_r <= need_nxt;
    s_r <= s_nxt; ps_r <= ps_nxt; ns_r <= ns_nxt; pf_r <= pf_nxt;
    nf_r <= nf_nxt; pv_r <= pv_nxt; nv_r <= nv_nxt;
  end

`include "first_fit_heap_allocator_assert.svh"
  `FFHA_ASSERT(a_onehot, clk, rst_n, $onehot(state_r))
  `FFHA_ASSERT(a_nospace_zero, clk, rst_n, (out_valid && out_status) |-> out_result_address == 32'd0)
  `FFHA_ASSERT(a_ready_excl, clk, rst_n, !(in_ready && out_valid))
  `FFHA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid && $stable(out_result_address))
endmodule
